/* design/button_press_classifier_defines.svh */
// Assertion macros for the button press classifier checker.
// Expects signals named clk and rst in the scope of use.
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// clocked assertion, off while rst is high
`define BPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also covers reset cycles
`define BPC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bpc_pkg.sv */
// Package for the button press classifier: payload and config types,
// codes, phase enum and the action mapping. No dependencies.
package bpc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_W       = 16;
  localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int HELD_W      = 17;
  localparam int ADDR_W      = 4;

  localparam logic [COUNT_WIDTH-1:0] TC_MAX   = {COUNT_WIDTH{1'b1}};
  localparam logic [HELD_W-1:0]      HELD_MAX = {HELD_W{1'b1}};

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] BTN_REFRESH = 2'd0;
  localparam logic [1:0] BTN_PREV    = 2'd1;
  localparam logic [1:0] BTN_ACTION  = 2'd2;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_REFRESH  = 2'd1;
  localparam logic [1:0] REG_ACTION   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT  = 2'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] REFRESH_RST  = 16'd3000;
  localparam logic [CFG_W-1:0] ACTION_RST   = 16'd1500;
  localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd5000;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2,
    PH_RELEASE  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_REFRESH = 3'd1,
    ACT_SERVICE = 3'd2,
    ACT_PREV    = 3'd3,
    ACT_NEXT    = 3'd4,
    ACT_SEND_QC = 3'd5
  } action_t;

  typedef struct packed {
    logic       op;
    logic [2:0] start_mask;
    logic [2:0] pressed;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        action;
    logic              ambiguous;
    logic              released;
    logic [HELD_W-1:0] held_ms;
    logic [2:0]        wake_mask;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] refresh_long_ms;
    logic [CFG_W-1:0] action_long_ms;
    logic [CFG_W-1:0] release_timeout_ms;
  } cfg_t;

  function automatic action_t map_action(input logic [1:0] idx, input logic lng);
    action_t a;
    case (idx)
      BTN_REFRESH: a = lng ? ACT_SERVICE : ACT_REFRESH;
      BTN_PREV:    a = ACT_PREV;
      default:     a = lng ? ACT_SEND_QC : ACT_NEXT;
    endcase
    return a;
  endfunction

endpackage

/* design/bpc_core.sv */
// Capture state machine: each transaction taken on step updates the registered state.
// Depends on bpc_pkg.
module bpc_core import bpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      emit,
  output out_item_t result
);

  typedef enum logic [2:0] {
    EMIT_NONE    = 3'd0,
    EMIT_EMPTY   = 3'd1,
    EMIT_AMBIG   = 3'd2,
    EMIT_NOPRESS = 3'd3,
    EMIT_FINAL   = 3'd4
  } emit_t;

  phase_t                 phase, phase_next;
  logic [1:0]             button_index, button_index_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic                   long_flag, long_flag_next;
  logic [HELD_W-1:0]      held_total, held_total_next;
  action_t                chosen_action, chosen_action_next;
  logic [2:0]             mask_copy, mask_copy_next;
  emit_t                  kind;
  logic                   lvl;

  always_comb begin
    logic [CFG_W-1:0] thr;
    logic [CMP_W:0]   sum;
    phase_next         = phase;
    button_index_next  = button_index;
    tick_count_next    = tick_count;
    long_flag_next     = long_flag;
    held_total_next    = held_total;
    chosen_action_next = chosen_action;
    mask_copy_next     = mask_copy;
    kind               = EMIT_NONE;
    thr                = '0;
    sum                = '0;

    if (item.op == OP_START) begin
      mask_copy_next = item.start_mask;
      phase_next     = PH_IDLE;
      if (item.start_mask == 3'd0) begin
        kind = EMIT_EMPTY;
      end else if ((item.start_mask & (item.start_mask - 3'd1)) != 3'd0) begin
        kind = EMIT_AMBIG;
      end else begin
        button_index_next  = item.start_mask[0] ? BTN_REFRESH :
                             item.start_mask[1] ? BTN_PREV : BTN_ACTION;
        tick_count_next    = '0;
        long_flag_next     = 1'b0;
        held_total_next    = '0;
        chosen_action_next = ACT_NONE;
        phase_next         = PH_DEBOUNCE;
      end
    end else if (phase != PH_IDLE) begin
      if (tick_count != TC_MAX) tick_count_next = tick_count + COUNT_WIDTH'(1);
    end

    case (button_index_next)
      BTN_REFRESH: lvl = item.pressed[0];
      BTN_PREV:    lvl = item.pressed[1];
      default:     lvl = item.pressed[2];
    endcase

    if (phase_next == PH_DEBOUNCE &&
        CMP_W'(tick_count_next) >= CMP_W'(cfg.debounce_ms)) begin
      if (!lvl) begin
        kind       = EMIT_NOPRESS;
        phase_next = PH_IDLE;
      end else begin
        phase_next      = PH_HOLD;
        tick_count_next = '0;
        long_flag_next  = 1'b0;
      end
    end

    if (phase_next == PH_HOLD) begin
      thr = (button_index_next == BTN_REFRESH) ? cfg.refresh_long_ms : cfg.action_long_ms;
      if (button_index_next == BTN_PREV || !lvl ||
          CMP_W'(tick_count_next) >= CMP_W'(thr)) begin
        long_flag_next     = (button_index_next != BTN_PREV) && lvl;
        sum                = (CMP_W+1)'(tick_count_next) + (CMP_W+1)'(cfg.debounce_ms);
        held_total_next    = (sum > (CMP_W+1)'(HELD_MAX)) ? HELD_MAX : sum[HELD_W-1:0];
        chosen_action_next = map_action(button_index_next, long_flag_next);
        phase_next         = PH_RELEASE;
        tick_count_next    = '0;
      end
    end

    if (phase_next == PH_RELEASE &&
        (!lvl || CMP_W'(tick_count_next) >= CMP_W'(cfg.release_timeout_ms))) begin
      kind       = EMIT_FINAL;
      phase_next = PH_IDLE;
    end
  end

  always_comb begin
    result = '0;
    emit   = step && (kind != EMIT_NONE);
    unique case (kind)
      EMIT_NONE, EMIT_EMPTY: begin
        result = '0;
      end
      EMIT_AMBIG: begin
        result.ambiguous = 1'b1;
        result.wake_mask = mask_copy_next;
      end
      EMIT_NOPRESS: begin
        result.wake_mask = mask_copy_next;
      end
      EMIT_FINAL: begin
        result.released  = !lvl;
        result.action    = lvl ? ACT_NONE : chosen_action_next;
        result.held_ms   = held_total_next;
        result.wake_mask = mask_copy_next;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      button_index  <= BTN_REFRESH;
      tick_count    <= '0;
      long_flag     <= 1'b0;
      held_total    <= '0;
      chosen_action <= ACT_NONE;
      mask_copy     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      button_index  <= button_index_next;
      tick_count    <= tick_count_next;
      long_flag     <= long_flag_next;
      held_total    <= held_total_next;
      chosen_action <= chosen_action_next;
      mask_copy     <= mask_copy_next;
    end
  end

endmodule

/* design/button_press_classifier.sv */
// Top level of the button press classifier: APB registers, input and
// result registers around bpc_core. Depends on bpc_pkg and bpc_core.
//
// Usage:
//  - in channel (in_valid/in_ready/in_data): one transaction per ms tick
//    (op = 0) or per capture start (op = 1) with the trigger mask.
//  - out channel (out_valid/out_ready/out_data): zero or one result per
//    input transaction, in order.
//  - APB port sets debounce, long-press thresholds and release timeout at
//    byte addresses 0, 4, 8, 12; write only while no capture is running.
//  - Throughput: one transaction per cycle while the output does not stall,
//    as the state update in bpc_core feeds itself.
//  - An accepted input passes the input register, then the state update
//    in bpc_core into the result register.
//  - Reset clears the capture state, drops held transactions and restores
//    the register defaults.
//  - When out_ready is low a result stays in the result register; one
//    more input transaction is held in the input register, then in_ready
//    drops until the result is taken.
module button_press_classifier import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t      cfg;
  logic      in_held;
  in_item_t  in_reg;
  logic      step;
  logic      emit;
  out_item_t result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms        <= DEBOUNCE_RST;
      cfg.refresh_long_ms    <= REFRESH_RST;
      cfg.action_long_ms     <= ACTION_RST;
      cfg.release_timeout_ms <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_DEBOUNCE: cfg.debounce_ms        <= pwdata[CFG_W-1:0];
        REG_REFRESH:  cfg.refresh_long_ms    <= pwdata[CFG_W-1:0];
        REG_ACTION:   cfg.action_long_ms     <= pwdata[CFG_W-1:0];
        REG_TIMEOUT:  cfg.release_timeout_ms <= pwdata[CFG_W-1:0];
        default:      cfg.debounce_ms        <= cfg.debounce_ms;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE: prdata = 32'(cfg.debounce_ms);
      REG_REFRESH:  prdata = 32'(cfg.refresh_long_ms);
      REG_ACTION:   prdata = 32'(cfg.action_long_ms);
      REG_TIMEOUT:  prdata = 32'(cfg.release_timeout_ms);
      default:      prdata = '0;
    endcase
  end

  assign step     = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_reg <= in_data;
  end

  bpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_reg),
    .cfg    (cfg),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= result;
  end

endmodule

/* design/bpc_checker.sv */
// Port-level checks for button_press_classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier_defines.svh.
`include "button_press_classifier_defines.svh"

module bpc_checker import bpc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `BPC_ASSERT_RST(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")

  `BPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  `BPC_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  `BPC_ASSERT(a_ambig_fields, out_valid && out_data.ambiguous |-> out_data.action == ACT_NONE && !out_data.released && out_data.held_ms == '0, "ambiguous result carries data")

  `BPC_ASSERT(a_unreleased_no_action, out_valid && !out_data.released |-> out_data.action == ACT_NONE, "action without release")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);
